[rtl/core/hpq_pkg.sv]
package hpq_pkg;

    // Heap geometry. Slots are numbered 1..CAPACITY; the RAM holds slot s at
    // address s-1.
    localparam int CAPACITY     = 256;
    localparam int SLOT_BITS    = $clog2(CAPACITY);
    localparam int COUNT_BITS   = $clog2(CAPACITY + 1);
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;

    // Field widths fixed by the interface.
    localparam int LIMIT_BITS     = 9;
    localparam int COUNT_OUT_BITS = 9;
    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 1;

    // Width that holds both the configured limit and the heap capacity.
    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS + 1 : LIMIT_BITS + 1;

    typedef enum logic {
        FUNC_INSERT  = 1'b0,
        FUNC_EXTRACT = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ORDER_MODE     = 1'b0,
        CFG_CAPACITY_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_READ,
        ST_UP_CMP,
        ST_DN_LOAD,
        ST_DN_READ,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        func_t                   func;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic [KEY_BITS-1:0]       key_out;
        logic [PAYLOAD_BITS-1:0]   payload_out;
        logic [COUNT_OUT_BITS-1:0] count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    // True when key a must leave strictly before key b.
    function automatic logic goes_first(input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b,
                                        input logic                largest_first);
        goes_first = largest_first ? (a > b) : (a < b);
    endfunction

endpackage

[rtl/core/binary_heap_priority_queue.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  hpq_pkg::req_t (func, key, payload)
// rsp       out        rsp_valid/rsp_stall  hpq_pkg::rsp_t (status, key_out,
//                                           payload_out, count)
// cfg       in         cfg_we               cfg_index, cfg_data
//
// One transaction at a time. An insert places the new entry in the hole at the
// next free slot and lets it climb toward the root (at most 8 levels); an
// extract returns the root, moves the last entry into the root hole and lets
// it sink (at most 7 levels), or goes to the done state after the root and the
// last entry are loaded when that empties the heap. Every level of a sift takes
// a read state and then a compare-and-write state on the single RAM. A refused
// insert or an extract on an empty heap goes straight to the done state. Reset
// clears the entry count, the state, the output valid flag and the configuration
// registers; the storage itself is not cleared, since only written slots are
// ever read.
// req_stall stays high while a transaction is in flight and while a finished
// result cannot yet move into the stalled output register.
module binary_heap_priority_queue (
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      req_valid,
    output logic                                      req_stall,
    input  hpq_pkg::req_t                             req,

    output logic                                      rsp_valid,
    input  logic                                      rsp_stall,
    output hpq_pkg::rsp_t                             rsp,

    input  logic                                      cfg_we,
    input  logic [hpq_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [hpq_pkg::CFG_DATA_BITS-1:0]         cfg_data
);

    localparam int CB = hpq_pkg::COUNT_BITS;
    localparam int SB = hpq_pkg::SLOT_BITS;

    // Control state.
    hpq_pkg::state_t                 state_reg, state_next;
    logic [CB-1:0]                   count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            order_mode_reg;
    logic [hpq_pkg::LIMIT_BITS-1:0]  capacity_limit_reg;

    // Working registers: the entry being moved, the hole it sits in, and the
    // result being built.
    logic [CB-1:0]                   slot_reg, slot_next;
    hpq_pkg::entry_t                 cur_reg, cur_next;
    hpq_pkg::rsp_t                   res_reg, res_next;
    hpq_pkg::rsp_t                   out_reg, out_next;

    // RAM port signals.
    logic                            ram_we;
    logic [SB-1:0]                   ram_waddr;
    hpq_pkg::entry_t                 ram_wdata;
    logic [SB-1:0]                   ram_raddr_a;
    logic [SB-1:0]                   ram_raddr_b;
    hpq_pkg::entry_t                 ram_rdata_a;
    hpq_pkg::entry_t                 ram_rdata_b;

    // Slot arithmetic. Children of slot s are 2s and 2s+1, the parent is s/2.
    logic [CB-1:0]                   slot_m1;
    logic [CB-1:0]                   parent;
    logic [CB-1:0]                   parent_m1;
    logic [CB:0]                     lft;
    logic [CB:0]                     rgt;
    logic [CB:0]                     lft_m1;
    logic [CB-1:0]                   count_m1;
    logic                            lft_ok;
    logic                            rgt_ok;

    // Insert acceptance limit: the configured limit clamped to the capacity.
    logic [hpq_pkg::CMP_BITS-1:0]    limit_wide;
    logic                            heap_full;

    // Sift-down decision.
    logic                            take_l;
    logic                            take_r;
    logic [hpq_pkg::KEY_BITS-1:0]    best_key;

    assign slot_m1   = slot_reg - CB'(1);
    assign parent    = slot_reg >> 1;
    assign parent_m1 = parent - CB'(1);
    assign lft       = {slot_reg, 1'b0};
    assign rgt       = {slot_reg, 1'b1};
    assign lft_m1    = lft - (CB+1)'(1);
    assign count_m1  = count_reg - CB'(1);
    assign lft_ok    = (lft <= {1'b0, count_reg});
    assign rgt_ok    = (rgt <= {1'b0, count_reg});

    assign limit_wide = (hpq_pkg::CMP_BITS'(capacity_limit_reg) >
                         hpq_pkg::CMP_BITS'(hpq_pkg::CAPACITY))
                        ? hpq_pkg::CMP_BITS'(hpq_pkg::CAPACITY)
                        : hpq_pkg::CMP_BITS'(capacity_limit_reg);
    assign heap_full  = (hpq_pkg::CMP_BITS'(count_reg) >= limit_wide);

    // The left child wins over the hole's entry only when strictly first; the
    // right child must then be strictly first against the current winner.
    assign take_l   = lft_ok && hpq_pkg::goes_first(ram_rdata_a.key, cur_reg.key,
                                                    order_mode_reg);
    assign best_key = take_l ? ram_rdata_a.key : cur_reg.key;
    assign take_r   = rgt_ok && hpq_pkg::goes_first(ram_rdata_b.key, best_key,
                                                    order_mode_reg);

    hpq_ram #(
        .WIDTH ($bits(hpq_pkg::entry_t)),
        .DEPTH (hpq_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign req_stall = (state_reg != hpq_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Configuration registers. Writes must arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg     <= 1'b0;
            capacity_limit_reg <= hpq_pkg::LIMIT_BITS'(hpq_pkg::CAPACITY);
        end
        else if (cfg_we)
        begin
            unique case (hpq_pkg::cfg_index_t'(cfg_index))
                hpq_pkg::CFG_ORDER_MODE:     order_mode_reg     <= cfg_data[0];
                hpq_pkg::CFG_CAPACITY_LIMIT: capacity_limit_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    // Sequencer. Each level of a sift passes through a read state and then a
    // compare-and-write state. The moving entry rides in cur_reg and the slot
    // it would occupy (the hole) in slot_reg, so a swap becomes a single
    // write of the displaced neighbor into the hole.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        ram_we      = 1'b0;
        ram_waddr   = slot_m1[SB-1:0];
        ram_wdata   = cur_reg;
        ram_raddr_a = parent_m1[SB-1:0];
        ram_raddr_b = count_m1[SB-1:0];

        // The consumer took the pending result.
        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            hpq_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.key_out     = '0;
                    res_next.payload_out = '0;
                    res_next.count       = hpq_pkg::COUNT_OUT_BITS'(count_reg);
                    if (req.func == hpq_pkg::FUNC_INSERT)
                    begin
                        if (heap_full)
                        begin
                            res_next.status = hpq_pkg::STATUS_FULL;
                            state_next      = hpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            count_next       = count_reg + CB'(1);
                            slot_next        = count_reg + CB'(1);
                            cur_next.key     = req.key;
                            cur_next.payload = req.payload;
                            res_next.status  = hpq_pkg::STATUS_DONE;
                            res_next.count   =
                                hpq_pkg::COUNT_OUT_BITS'(count_reg + CB'(1));
                            state_next       = hpq_pkg::ST_UP_READ;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = hpq_pkg::STATUS_EMPTY;
                            state_next      = hpq_pkg::ST_DONE;
                        end
                        else
                        begin
                            // Fetch the root and the last entry together.
                            ram_raddr_a = '0;
                            ram_raddr_b = count_m1[SB-1:0];
                            state_next  = hpq_pkg::ST_DN_LOAD;
                        end
                    end
                end
            end

            hpq_pkg::ST_UP_READ:
            begin
                if (slot_reg == CB'(1))
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cur_reg;
                    state_next = hpq_pkg::ST_DONE;
                end
                else
                begin
                    ram_raddr_a = parent_m1[SB-1:0];
                    state_next  = hpq_pkg::ST_UP_CMP;
                end
            end

            hpq_pkg::ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (hpq_pkg::goes_first(cur_reg.key, ram_rdata_a.key, order_mode_reg))
                begin
                    // Parent drops into the hole; the hole climbs.
                    ram_wdata  = ram_rdata_a;
                    slot_next  = parent;
                    state_next = hpq_pkg::ST_UP_READ;
                end
                else
                begin
                    ram_wdata  = cur_reg;
                    state_next = hpq_pkg::ST_DONE;
                end
            end

            hpq_pkg::ST_DN_LOAD:
            begin
                res_next.status      = hpq_pkg::STATUS_DONE;
                res_next.key_out     = ram_rdata_a.key;
                res_next.payload_out = ram_rdata_a.payload;
                res_next.count       = hpq_pkg::COUNT_OUT_BITS'(count_m1);
                cur_next             = ram_rdata_b;
                count_next           = count_m1;
                slot_next            = CB'(1);
                state_next           = (count_m1 == '0) ? hpq_pkg::ST_DONE
                                                        : hpq_pkg::ST_DN_READ;
            end

            hpq_pkg::ST_DN_READ:
            begin
                if (!lft_ok)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = cur_reg;
                    state_next = hpq_pkg::ST_DONE;
                end
                else
                begin
                    ram_raddr_a = lft_m1[SB-1:0];
                    ram_raddr_b = lft[SB-1:0];
                    state_next  = hpq_pkg::ST_DN_CMP;
                end
            end

            hpq_pkg::ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (take_r)
                begin
                    ram_wdata  = ram_rdata_b;
                    slot_next  = rgt[CB-1:0];
                    state_next = hpq_pkg::ST_DN_READ;
                end
                else if (take_l)
                begin
                    ram_wdata  = ram_rdata_a;
                    slot_next  = lft[CB-1:0];
                    state_next = hpq_pkg::ST_DN_READ;
                end
                else
                begin
                    ram_wdata  = cur_reg;
                    state_next = hpq_pkg::ST_DONE;
                end
            end

            hpq_pkg::ST_DONE:
            begin
                // Move the result out once the output register is free.
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = hpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = hpq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/hpq_ram.sv]
// Simple dual-read RAM: one write port, two read ports, registered read data.
module hpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule
